>>> sv/linear_probe_hash_table_assert.svh
// Assertion macros used by the checker of this block.
`ifndef LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LPH_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lph: check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LPH_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lph: check failed");

`endif

>>> sv/lph_pkg.sv
package lph_pkg;

  localparam int CFG_W      = 11;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 3;
  localparam int MARK_W     = 2;
  localparam int SIZE_RESET = 10;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_FOUND    = 3'd1,
    ST_DELETED  = 3'd2,
    ST_MISSING  = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  typedef enum logic [MARK_W-1:0] {
    MARK_EMPTY = 2'd0,
    MARK_USED  = 2'd1,
    MARK_GONE  = 2'd2
  } mark_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_RD,
    S_CHK,
    S_DONE
  } state_e;

  typedef struct packed {
    logic clear;
    logic load;
    logic div_step;
    logic advance;
    logic resolve;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic div_last;
    logic probe_done;
    logic out_free;
  } sts_t;

endpackage

>>> sv/linear_probe_hash_table.sv
// Open-addressing hash table with linear probing, one request at a time.
// Slave stream: tuser = operation (0 insert, 1 search, 2 delete), tdata = key.
// Master stream: tuser = status, tdata = slot_index then element_count.
// Config channel: cfg_valid_i/cfg_ready_o/cfg_data_i writes table_size;
//   always ready, write only while no request is in flight.
// Home slot = key mod table_size, computed bit-serially.
// Each probe is a registered RAM read, then a check and write back.
// The next item is taken in the cycle after the result is loaded into the
//   output register. P, the number of probes, is 1 for a hit at the home slot
//   and at most table_size.
// After reset the slot memory is swept to empty, one slot a cycle, with
//   s_axis_tready low; table_size resets to 10 (CAPACITY if smaller).
// The result sits in an output register; while the receiver stalls the block
//   may take the next item and compute it, then holds until the register frees.
module linear_probe_hash_table #(
  parameter int CAPACITY = 1024,
  parameter int KEY_BITS = 31
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        s_axis_tvalid,
  output logic                                        s_axis_tready,
  // [KEY_BITS-1:0] key, zero padded to bytes
  input  logic [((KEY_BITS+7)/8)*8-1:0]               s_axis_tdata,
  // [1:0] operation
  input  logic [lph_pkg::OP_W-1:0]                    s_axis_tuser,
  output logic                                        m_axis_tvalid,
  input  logic                                        m_axis_tready,
  // [SW-1:0] slot_index, [SW+CW-1:SW] element_count, zero padded to bytes
  output logic [(($clog2(CAPACITY)+$clog2(CAPACITY+1)+7)/8)*8-1:0] m_axis_tdata,
  // [2:0] status
  output logic [lph_pkg::STATUS_W-1:0]                m_axis_tuser,
  input  logic                                        cfg_valid_i,
  output logic                                        cfg_ready_o,
  input  logic [lph_pkg::CFG_W-1:0]                   cfg_data_i
);

  localparam int SW    = $clog2(CAPACITY);
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int OUT_W = ((SW + CW + 7) / 8) * 8;
  localparam int RAM_W = KEY_BITS + lph_pkg::MARK_W;

  lph_pkg::cmd_t     cmd;
  lph_pkg::sts_t     sts;
  logic              ram_we;
  logic [SW-1:0]     ram_addr;
  logic [RAM_W-1:0]  ram_wdata, ram_rdata;
  logic [SW-1:0]     m_slot;
  logic [CW-1:0]     m_count;

  assign cfg_ready_o  = 1'b1;
  assign m_axis_tdata = OUT_W'({m_count, m_slot});

  lph_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  lph_dp #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS),
    .SW       (SW),
    .CW       (CW)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .op_i        (s_axis_tuser),
    .key_i       (s_axis_tdata[KEY_BITS-1:0]),
    .ram_we_o    (ram_we),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .ram_rdata_i (ram_rdata),
    .m_ready_i   (m_axis_tready),
    .m_valid_o   (m_axis_tvalid),
    .m_status_o  (m_axis_tuser),
    .m_slot_o    (m_slot),
    .m_count_o   (m_count)
  );

  lph_ram #(
    .WIDTH (RAM_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

endmodule

>>> sv/lph_ram.sv
module lph_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/lph_ctrl.sv
module lph_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  output logic          s_ready_o,
  input  lph_pkg::sts_t sts_i,
  output lph_pkg::cmd_t cmd_o
);

  lph_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lph_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lph_pkg::S_CLEAR: begin
        if (sts_i.clear_last) state_d = lph_pkg::S_IDLE;
      end
      lph_pkg::S_IDLE: begin
        if (s_valid_i) state_d = lph_pkg::S_DIV;
      end
      lph_pkg::S_DIV: begin
        if (sts_i.div_last) state_d = lph_pkg::S_RD;
      end
      lph_pkg::S_RD: begin
        state_d = lph_pkg::S_CHK;
      end
      lph_pkg::S_CHK: begin
        state_d = sts_i.probe_done ? lph_pkg::S_DONE : lph_pkg::S_RD;
      end
      lph_pkg::S_DONE: begin
        if (sts_i.out_free) state_d = lph_pkg::S_IDLE;
      end
      default: state_d = lph_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o     = '0;
    s_ready_o = 1'b0;
    unique case (state_q)
      lph_pkg::S_CLEAR: cmd_o.clear = 1'b1;
      lph_pkg::S_IDLE: begin
        s_ready_o  = 1'b1;
        cmd_o.load = s_valid_i;
      end
      lph_pkg::S_DIV: cmd_o.div_step = 1'b1;
      lph_pkg::S_RD: ;
      lph_pkg::S_CHK: begin
        cmd_o.resolve = sts_i.probe_done;
        cmd_o.advance = !sts_i.probe_done;
      end
      lph_pkg::S_DONE: cmd_o.emit = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

>>> sv/lph_dp.sv
module lph_dp #(
  parameter int CAPACITY = 1024,
  parameter int KEY_BITS = 31,
  parameter int SW       = $clog2(CAPACITY),
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lph_pkg::cmd_t                cmd_i,
  output lph_pkg::sts_t                sts_o,
  input  logic                         cfg_valid_i,
  input  logic [lph_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic [lph_pkg::OP_W-1:0]     op_i,
  input  logic [KEY_BITS-1:0]          key_i,
  output logic                         ram_we_o,
  output logic [SW-1:0]                ram_addr_o,
  output logic [KEY_BITS+lph_pkg::MARK_W-1:0] ram_wdata_o,
  input  logic [KEY_BITS+lph_pkg::MARK_W-1:0] ram_rdata_i,
  input  logic                         m_ready_i,
  output logic                         m_valid_o,
  output logic [lph_pkg::STATUS_W-1:0] m_status_o,
  output logic [SW-1:0]                m_slot_o,
  output logic [CW-1:0]                m_count_o
);

  localparam int DCW      = $clog2(KEY_BITS);
  localparam int CMPW     = (lph_pkg::CFG_W > CW) ? lph_pkg::CFG_W : CW;
  localparam int RST_SIZE = (CAPACITY < lph_pkg::SIZE_RESET) ? CAPACITY
                                                             : lph_pkg::SIZE_RESET;

  logic [CW-1:0]                size_q, count_q;
  logic [SW-1:0]                clr_addr_q;
  logic [lph_pkg::OP_W-1:0]     op_q;
  logic [KEY_BITS-1:0]          key_q, kshift_q;
  logic [CW-1:0]                rem_q, n_q;
  logic [DCW-1:0]               dcnt_q;
  logic [SW-1:0]                pos_q;
  logic [lph_pkg::STATUS_W-1:0] res_status_q, m_status_q;
  logic [SW-1:0]                res_slot_q, m_slot_q;
  logic [CW-1:0]                m_count_q;
  logic                         m_valid_q;

  logic [CMPW-1:0]              cfg_ext;
  logic [CW-1:0]                size_new;
  logic [CW:0]                  rem_sh, rem_sub, size_ext;
  logic [CW-1:0]                rem_nx;
  lph_pkg::mark_e               rd_mark;
  logic [KEY_BITS-1:0]          rd_key;
  logic                         hit, last_probe, lookup_op;
  logic [lph_pkg::STATUS_W-1:0] res_status_d;
  logic [SW-1:0]                res_slot_d;
  logic                         wr_en;
  lph_pkg::mark_e               wr_mark;
  logic [CW-1:0]                count_d;

  // table size: zero reads as one, oversize saturates
  always_comb begin
    cfg_ext = CMPW'(cfg_data_i);
    if (cfg_ext == '0) begin
      size_new = CW'(1);
    end else if (cfg_ext > CMPW'(CAPACITY)) begin
      size_new = CW'(CAPACITY);
    end else begin
      size_new = CW'(cfg_ext);
    end
  end

  // restoring remainder, one key bit per step
  always_comb begin
    size_ext = {1'b0, size_q};
    rem_sh   = {rem_q, kshift_q[KEY_BITS-1]};
    rem_sub  = rem_sh - size_ext;
    rem_nx   = (rem_sh >= size_ext) ? CW'(rem_sub) : CW'(rem_sh);
  end

  always_comb begin
    rd_mark    = lph_pkg::mark_e'(ram_rdata_i[KEY_BITS +: lph_pkg::MARK_W]);
    rd_key     = ram_rdata_i[KEY_BITS-1:0];
    last_probe = (n_q == size_q - CW'(1));
    lookup_op  = (op_q == lph_pkg::OP_SEARCH) || (op_q == lph_pkg::OP_DELETE);
    case (op_q) inside
      lph_pkg::OP_INSERT: hit = (rd_mark != lph_pkg::MARK_USED);
      lph_pkg::OP_SEARCH,
      lph_pkg::OP_DELETE: hit = (rd_mark == lph_pkg::MARK_USED) && (rd_key == key_q);
      default:            hit = 1'b0;
    endcase
  end

  always_comb begin
    res_status_d = lph_pkg::ST_MISSING;
    res_slot_d   = '0;
    wr_en        = 1'b0;
    wr_mark      = lph_pkg::MARK_USED;
    count_d      = count_q;
    case (op_q)
      lph_pkg::OP_INSERT: begin
        if (hit) begin
          res_status_d = lph_pkg::ST_INSERTED;
          res_slot_d   = pos_q;
          wr_en        = 1'b1;
          count_d      = count_q + CW'(1);
        end else begin
          res_status_d = lph_pkg::ST_FULL;
        end
      end
      lph_pkg::OP_SEARCH: begin
        if (hit) begin
          res_status_d = lph_pkg::ST_FOUND;
          res_slot_d   = pos_q;
        end
      end
      lph_pkg::OP_DELETE: begin
        if (hit) begin
          res_status_d = lph_pkg::ST_DELETED;
          res_slot_d   = pos_q;
          wr_en        = 1'b1;
          wr_mark      = lph_pkg::MARK_GONE;
          if (count_q != '0) count_d = count_q - CW'(1);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    ram_we_o = cmd_i.clear || (cmd_i.resolve && wr_en);
    if (cmd_i.clear) begin
      ram_addr_o  = clr_addr_q;
      ram_wdata_o = {lph_pkg::MARK_EMPTY, KEY_BITS'(0)};
    end else begin
      ram_addr_o  = pos_q;
      ram_wdata_o = (wr_mark == lph_pkg::MARK_GONE) ? {wr_mark, rd_key} : {wr_mark, key_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q     <= CW'(RST_SIZE);
      count_q    <= '0;
      clr_addr_q <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) size_q <= size_new;
      if (cmd_i.clear) clr_addr_q <= clr_addr_q + SW'(1);
      if (cmd_i.resolve) count_q <= count_d;
      if (cmd_i.emit) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= op_i;
      key_q    <= key_i;
      kshift_q <= key_i;
      rem_q    <= '0;
      dcnt_q   <= DCW'(KEY_BITS - 1);
      n_q      <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q    <= rem_nx;
      kshift_q <= kshift_q << 1;
      dcnt_q   <= dcnt_q - DCW'(1);
      if (dcnt_q == '0) pos_q <= SW'(rem_nx);
    end
    if (cmd_i.advance) begin
      pos_q <= (CW'(pos_q) + CW'(1) == size_q) ? '0 : pos_q + SW'(1);
      n_q   <= n_q + CW'(1);
    end
    if (cmd_i.resolve) begin
      res_status_q <= res_status_d;
      res_slot_q   <= res_slot_d;
    end
    if (cmd_i.emit) begin
      m_status_q <= res_status_q;
      m_slot_q   <= res_slot_q;
      m_count_q  <= count_q;
    end
  end

  always_comb begin
    sts_o.clear_last = (clr_addr_q == SW'(CAPACITY - 1));
    sts_o.div_last   = (dcnt_q == '0);
    sts_o.probe_done = hit || last_probe || !(lookup_op || op_q == lph_pkg::OP_INSERT) ||
                       (lookup_op && rd_mark == lph_pkg::MARK_EMPTY);
    sts_o.out_free   = !m_valid_q || m_ready_i;
  end

  assign m_valid_o  = m_valid_q;
  assign m_status_o = m_status_q;
  assign m_slot_o   = m_slot_q;
  assign m_count_o  = m_count_q;

endmodule

>>> sv/lph_checker.sv
`include "linear_probe_hash_table_assert.svh"

module lph_checker #(
  parameter int CAPACITY = 1024,
  parameter int KEY_BITS = 31
) (
  input logic                                        clk_i,
  input logic                                        rst_ni,
  input logic                                        s_axis_tvalid,
  input logic                                        s_axis_tready,
  input logic [((KEY_BITS+7)/8)*8-1:0]               s_axis_tdata,
  input logic [lph_pkg::OP_W-1:0]                    s_axis_tuser,
  input logic                                        m_axis_tvalid,
  input logic                                        m_axis_tready,
  input logic [(($clog2(CAPACITY)+$clog2(CAPACITY+1)+7)/8)*8-1:0] m_axis_tdata,
  input logic [lph_pkg::STATUS_W-1:0]                m_axis_tuser,
  input logic                                        cfg_valid_i,
  input logic                                        cfg_ready_o,
  input logic [lph_pkg::CFG_W-1:0]                   cfg_data_i
);

  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic miss_out;

  assign miss_out = (m_axis_tuser == lph_pkg::ST_MISSING) || (m_axis_tuser == lph_pkg::ST_FULL);

  // one request in flight: ready drops right after an accept
  `LPH_ASSERT_NXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  `LPH_ASSERT_IMP(a_status_code, m_axis_tvalid, m_axis_tuser <= lph_pkg::ST_FULL)

  // misses and full report slot zero
  `LPH_ASSERT_IMP(a_miss_slot, m_axis_tvalid && miss_out, m_axis_tdata[SW-1:0] == '0)

  `LPH_ASSERT_IMP(a_count_range, m_axis_tvalid, m_axis_tdata[SW+CW-1:SW] <= CW'(CAPACITY))

  `LPH_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind linear_probe_hash_table lph_checker #(
  .CAPACITY (CAPACITY),
  .KEY_BITS (KEY_BITS)
) u_lph_checker (.*);
